### sv/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// Peer table random sampler package
// Shared constants and codes for the peer table sampler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

	// Default table depth.
	localparam int PEER_SLOTS_DEF = 64;

	// Most results one list item may give.
	localparam int MAX_RESULTS = 64;

	// Fixed field widths.
	localparam int EP_W   = 48;
	localparam int TIME_W = 32;
	localparam int RNG_W  = 32;
	localparam int VAL_W  = 16;
	localparam int REQ_W  = 7;
	localparam int STAT_W = 3;
	localparam int OP_W   = 2;
	localparam int CIDX_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_LIST   = 2'd1;
	localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_LISTED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd2;
	localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd3;
	localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd5;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_VALIDITY = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SEED     = 2'd1;

	// Reset values of the registers.
	localparam logic [VAL_W-1:0] VALIDITY_RST = 16'd3600;
	localparam logic [RNG_W-1:0] SEED_RST     = 32'd1;

endpackage

### sv/ptrs_slot_mem.sv
// ----------------------------------------------------------------------------
// Peer table slot memory
// One write port and one read port with registered read data, holding the
// endpoint and last-seen time of each slot.
// ----------------------------------------------------------------------------
module ptrs_slot_mem #(
	parameter int PEER_SLOTS = ptrs_pkg::PEER_SLOTS_DEF,
	parameter int IDX_W      = $clog2(PEER_SLOTS)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IDX_W-1:0]            waddr,
	input  logic [ptrs_pkg::EP_W-1:0]   wep,
	input  logic [ptrs_pkg::TIME_W-1:0] wls,
	input  logic [IDX_W-1:0]            raddr,
	output logic [ptrs_pkg::EP_W-1:0]   rep,
	output logic [ptrs_pkg::TIME_W-1:0] rls
);

	logic [ptrs_pkg::EP_W-1:0]   ep_mem [PEER_SLOTS];
	logic [ptrs_pkg::TIME_W-1:0] ls_mem [PEER_SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			ep_mem[waddr] <= wep;
			ls_mem[waddr] <= wls;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rep <= ep_mem[raddr];
		rls <= ls_mem[raddr];
	end

endmodule

### sv/peer_table_random_sampler_top.sv
// ----------------------------------------------------------------------------
// Peer table random sampler
// Dense peer table with add/refresh, random listing by partial Fisher-Yates
// shuffle, and expiry of stale entries, run by a small sequencer.
// ----------------------------------------------------------------------------
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------
// command   | operation, endpoint, request_count, now_seconds | start & !busy
// result    | peer_endpoint, status, removed_count, last      | result_valid
// config    | cfg_index, cfg_data                            | cfg_valid&ready
//
// An add compares the filled slots one at a time with the endpoint. A list
// draws for each peer, reduces the draw modulo the span in the bit-serial
// modulo unit, then reads and swaps two slots. An expire checks each slot and
// pulls the last entry into each stale one. An empty list or an unused
// operation leaves busy low. Each result word is shown for one cycle and the
// receiver cannot stall; configuration is taken only while idle.
// After reset the table is empty, validity is 3600 and the generator holds 1.
// ----------------------------------------------------------------------------
module peer_table_random_sampler_top #(
	parameter int PEER_SLOTS = ptrs_pkg::PEER_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ptrs_pkg::OP_W-1:0]     operation,
	input  logic [ptrs_pkg::EP_W-1:0]     endpoint,
	input  logic [ptrs_pkg::REQ_W-1:0]    request_count,
	input  logic [ptrs_pkg::TIME_W-1:0]   now_seconds,
	output logic                          result_valid,
	output logic [ptrs_pkg::EP_W-1:0]     peer_endpoint,
	output logic [ptrs_pkg::STAT_W-1:0]   status,
	output logic [ptrs_pkg::REQ_W-1:0]    removed_count,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptrs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [ptrs_pkg::RNG_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(PEER_SLOTS);
	localparam int CNT_W = $clog2(PEER_SLOTS + 1);
	localparam int EP_W  = ptrs_pkg::EP_W;
	localparam int TW    = ptrs_pkg::TIME_W;
	localparam int RW    = ptrs_pkg::RNG_W;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_A_RD  = 4'd1;
	localparam logic [3:0] S_A_CMP = 4'd2;
	localparam logic [3:0] S_L_RNG = 4'd3;
	localparam logic [3:0] S_L_DIV = 4'd4;
	localparam logic [3:0] S_L_RDT = 4'd5;
	localparam logic [3:0] S_L_RDI = 4'd6;
	localparam logic [3:0] S_L_SW1 = 4'd7;
	localparam logic [3:0] S_L_SW2 = 4'd8;
	localparam logic [3:0] S_E_RD  = 4'd9;
	localparam logic [3:0] S_E_CHK = 4'd10;
	localparam logic [3:0] S_E_MV  = 4'd11;

	logic [3:0]                 state_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           idx_q;
	logic [CNT_W-1:0]           n_q;
	logic [CNT_W-1:0]           removed_q;
	logic [CNT_W-1:0]           rem_q;
	logic [RW-1:0]              div_q;
	logic [4:0]                 bit_q;
	logic [RW-1:0]              rng_q;
	logic [ptrs_pkg::VAL_W-1:0] validity_q;
	logic [EP_W-1:0]            ep_q;
	logic [TW-1:0]              now_q;
	logic [EP_W-1:0]            te_q;
	logic [TW-1:0]              tl_q;

	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [EP_W-1:0]            mem_wep;
	logic [TW-1:0]              mem_wls;
	logic [IDX_W-1:0]           mem_raddr;
	logic [EP_W-1:0]            rd_ep;
	logic [TW-1:0]              rd_ls;

	logic [RW-1:0]              rng_next;
	logic [CNT_W-1:0]           span;
	logic [CNT_W:0]             rem_sh;
	logic [CNT_W-1:0]           rem_nx;
	logic [CNT_W-1:0]           t_idx;
	logic [CNT_W-1:0]           last_idx;
	logic [CNT_W-1:0]           n_calc;
	logic [TW:0]                limit;
	logic                       stale;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Xorshift step.
	always_comb begin
		rng_next = rng_q ^ (rng_q << 13);
		rng_next = rng_next ^ (rng_next >> 17);
		rng_next = rng_next ^ (rng_next << 5);
	end

	// One restoring step of the bit-serial modulo unit.
	assign span   = count_q - idx_q;
	assign rem_sh = {rem_q, div_q[RW-1]};
	assign rem_nx = (rem_sh >= {1'b0, span}) ? CNT_W'(rem_sh - {1'b0, span})
	                                         : CNT_W'(rem_sh);
	assign t_idx    = idx_q + rem_q;
	assign last_idx = count_q - CNT_W'(1);

	// Expiry test without wrap.
	assign limit = {1'b0, rd_ls} + (TW + 1)'(validity_q);
	assign stale = limit < {1'b0, now_q};

	// Clamp the list length to the table fill and the result limit.
	always_comb begin
		n_calc = CNT_W'(request_count);
		if ({{(32 - ptrs_pkg::REQ_W){1'b0}}, request_count} > 32'(count_q)) begin
			n_calc = count_q;
		end
		if (32'(n_calc) > 32'(ptrs_pkg::MAX_RESULTS)) begin
			n_calc = CNT_W'(ptrs_pkg::MAX_RESULTS);
		end
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wep   = ep_q;
		mem_wls   = now_q;
		mem_raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_A_RD: begin
				mem_waddr = count_q[IDX_W-1:0];
				mem_we    = (idx_q == count_q) && (count_q != CNT_W'(PEER_SLOTS));
			end
			S_A_CMP: begin
				mem_we = (rd_ep == ep_q);
			end
			S_L_RDT: begin
				mem_raddr = t_idx[IDX_W-1:0];
			end
			S_L_SW1: begin
				mem_we    = 1'b1;
				mem_waddr = t_idx[IDX_W-1:0];
				mem_wep   = rd_ep;
				mem_wls   = rd_ls;
			end
			S_L_SW2: begin
				mem_we  = 1'b1;
				mem_wep = te_q;
				mem_wls = tl_q;
			end
			S_E_CHK: begin
				mem_raddr = last_idx[IDX_W-1:0];
			end
			S_E_MV: begin
				mem_we  = 1'b1;
				mem_wep = rd_ep;
				mem_wls = rd_ls;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	ptrs_slot_mem #(
		.PEER_SLOTS (PEER_SLOTS),
		.IDX_W      (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wep   (mem_wep),
		.wls   (mem_wls),
		.raddr (mem_raddr),
		.rep   (rd_ep),
		.rls   (rd_ls)
	);

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			ep_q  <= endpoint;
			now_q <= now_seconds;
		end
		if (state_q == S_L_RDI) begin
			te_q <= rd_ep;
			tl_q <= rd_ls;
		end
	end

	// Sequencer, table fill, generator and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			n_q           <= '0;
			removed_q     <= '0;
			rem_q         <= '0;
			div_q         <= '0;
			bit_q         <= '0;
			rng_q         <= ptrs_pkg::SEED_RST;
			validity_q    <= ptrs_pkg::VALIDITY_RST;
			result_valid  <= 1'b0;
			peer_endpoint <= '0;
			status        <= '0;
			removed_count <= '0;
			last          <= 1'b0;
		end else begin
			result_valid <= 1'b0;

			// Configuration writes, taken only while idle.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ptrs_pkg::REG_VALIDITY) begin
					validity_q <= cfg_data[ptrs_pkg::VAL_W-1:0];
				end else if (cfg_index == ptrs_pkg::REG_SEED) begin
					rng_q <= (cfg_data == '0) ? RW'(1) : cfg_data;
				end
			end

			case (state_q)
				S_IDLE: begin
					idx_q     <= '0;
					removed_q <= '0;
					n_q       <= n_calc;
					if (start) begin
						if (operation == ptrs_pkg::OP_ADD) begin
							state_q <= S_A_RD;
						end else if (operation == ptrs_pkg::OP_LIST) begin
							if (n_calc == '0) begin
								result_valid  <= 1'b1;
								peer_endpoint <= '0;
								status        <= ptrs_pkg::ST_EMPTY;
								removed_count <= '0;
								last          <= 1'b1;
							end else begin
								state_q <= S_L_RNG;
							end
						end else if (operation == ptrs_pkg::OP_EXPIRE) begin
							state_q <= S_E_RD;
						end
					end
				end

				// Add: search one slot at a time, reading then comparing.
				S_A_RD: begin
					if (idx_q == count_q) begin
						result_valid  <= 1'b1;
						peer_endpoint <= '0;
						removed_count <= '0;
						last          <= 1'b1;
						state_q       <= S_IDLE;
						if (count_q != CNT_W'(PEER_SLOTS)) begin
							count_q <= count_q + CNT_W'(1);
							status  <= ptrs_pkg::ST_ADDED;
						end else begin
							status <= ptrs_pkg::ST_DROPPED;
						end
					end else begin
						state_q <= S_A_CMP;
					end
				end
				S_A_CMP: begin
					if (rd_ep == ep_q) begin
						result_valid  <= 1'b1;
						peer_endpoint <= '0;
						status        <= ptrs_pkg::ST_REFRESHED;
						removed_count <= '0;
						last          <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_A_RD;
					end
				end

				// List: draw, reduce modulo the span, then swap.
				S_L_RNG: begin
					rng_q   <= rng_next;
					div_q   <= rng_next;
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= S_L_DIV;
				end
				S_L_DIV: begin
					rem_q <= rem_nx;
					div_q <= div_q << 1;
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd31) begin
						state_q <= S_L_RDT;
					end
				end
				S_L_RDT: begin
					state_q <= S_L_RDI;
				end
				S_L_RDI: begin
					state_q <= S_L_SW1;
				end
				S_L_SW1: begin
					result_valid  <= 1'b1;
					peer_endpoint <= te_q;
					status        <= ptrs_pkg::ST_LISTED;
					removed_count <= '0;
					last          <= (idx_q + CNT_W'(1)) == n_q;
					state_q       <= S_L_SW2;
				end
				S_L_SW2: begin
					idx_q <= idx_q + CNT_W'(1);
					if ((idx_q + CNT_W'(1)) == n_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_L_RNG;
					end
				end

				// Expire: check each slot, pull the last entry into a stale one.
				S_E_RD: begin
					if (idx_q >= count_q) begin
						result_valid  <= 1'b1;
						peer_endpoint <= '0;
						status        <= ptrs_pkg::ST_EXPIRED;
						removed_count <= ptrs_pkg::REQ_W'(removed_q);
						last          <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_E_CHK;
					end
				end
				S_E_CHK: begin
					if (stale) begin
						state_q <= S_E_MV;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_E_RD;
					end
				end
				S_E_MV: begin
					count_q   <= last_idx;
					removed_q <= removed_q + CNT_W'(1);
					state_q   <= S_E_RD;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Peer table random sampler testbench
// Drives add, list, expire and unused commands through the start/busy port.
// A local model of the table, the xorshift generator and the registers
// predicts every result word, and a monitor checks each one in order.
// Registers are rewritten between phases once the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SLOTS = ptrs_pkg::PEER_SLOTS_DEF;
	localparam logic [ptrs_pkg::CIDX_W-1:0] REG_NONE = 2'd3;
	localparam logic [ptrs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 200;
	localparam int CMD_DEPTH = 512;
	localparam int EXP_DEPTH = 128;
	localparam int POOL_SIZE = 96;

	typedef struct packed {
		logic [ptrs_pkg::OP_W-1:0]   op;
		logic [ptrs_pkg::EP_W-1:0]   ep;
		logic [ptrs_pkg::REQ_W-1:0]  req;
		logic [ptrs_pkg::TIME_W-1:0] now;
	} peer_cmd_t;

	typedef struct packed {
		logic [ptrs_pkg::EP_W-1:0]   ep;
		logic [ptrs_pkg::STAT_W-1:0] st;
		logic [ptrs_pkg::REQ_W-1:0]  removed;
		logic                        last;
	} peer_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ptrs_pkg::OP_W-1:0] operation = '0;
	logic [ptrs_pkg::EP_W-1:0] endpoint = '0;
	logic [ptrs_pkg::REQ_W-1:0] request_count = '0;
	logic [ptrs_pkg::TIME_W-1:0] now_seconds = '0;
	logic result_valid;
	logic [ptrs_pkg::EP_W-1:0] peer_endpoint;
	logic [ptrs_pkg::STAT_W-1:0] status;
	logic [ptrs_pkg::REQ_W-1:0] removed_count;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ptrs_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [ptrs_pkg::RNG_W-1:0] cfg_data = '0;

	// Local copy of the table, generator and registers.
	logic [ptrs_pkg::EP_W-1:0] tbl_ep [SLOTS];
	logic [ptrs_pkg::TIME_W-1:0] tbl_seen [SLOTS];
	int unsigned tbl_count = 0;
	logic [ptrs_pkg::RNG_W-1:0] gen_state = ptrs_pkg::SEED_RST;
	logic [ptrs_pkg::VAL_W-1:0] validity = ptrs_pkg::VALIDITY_RST;

	// Pending commands and expected words, kept as arrays with counters.
	peer_cmd_t cmd_buf [CMD_DEPTH];
	int cmd_wr = 0;
	int cmd_rd = 0;
	peer_word_t exp_buf [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	logic [ptrs_pkg::EP_W-1:0] ep_pool [POOL_SIZE];
	logic [ptrs_pkg::TIME_W-1:0] clock_now = 0;
	int errors = 0;
	int burst_left = 4;
	int gap_left = 0;

	always #4 clk = ~clk;

	peer_table_random_sampler_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .endpoint(endpoint), .request_count(request_count),
		.now_seconds(now_seconds), .result_valid(result_valid),
		.peer_endpoint(peer_endpoint), .status(status),
		.removed_count(removed_count), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic logic [ptrs_pkg::RNG_W-1:0] gen_step();
		logic [ptrs_pkg::RNG_W-1:0] x;
		x = gen_state;
		x ^= x << 13;
		x ^= x >> 17;
		x ^= x << 5;
		gen_state = x;
		return x;
	endfunction

	function automatic void push_word(logic [ptrs_pkg::EP_W-1:0] ep,
			logic [ptrs_pkg::STAT_W-1:0] st, logic [ptrs_pkg::REQ_W-1:0] removed,
			logic lst);
		peer_word_t w;
		w.ep = ep;
		w.st = st;
		w.removed = removed;
		w.last = lst;
		exp_buf[exp_wr % EXP_DEPTH] = w;
		exp_wr++;
	endfunction

	// Apply one accepted command to the table and queue its result words.
	function automatic void predict_peers(peer_cmd_t c);
		int unsigned n;
		int unsigned pick;
		int unsigned removed;
		int unsigned k;
		logic [ptrs_pkg::EP_W-1:0] te;
		logic [ptrs_pkg::TIME_W-1:0] tl;
		logic [ptrs_pkg::TIME_W:0] limit;
		case (c.op)
			ptrs_pkg::OP_ADD: begin
				for (k = 0; k < tbl_count; k++) begin
					if (tbl_ep[k] == c.ep) begin
						tbl_seen[k] = c.now;
						push_word('0, ptrs_pkg::ST_REFRESHED, '0, 1'b1);
						return;
					end
				end
				if (tbl_count < SLOTS) begin
					tbl_ep[tbl_count] = c.ep;
					tbl_seen[tbl_count] = c.now;
					tbl_count++;
					push_word('0, ptrs_pkg::ST_ADDED, '0, 1'b1);
				end else begin
					push_word('0, ptrs_pkg::ST_DROPPED, '0, 1'b1);
				end
			end
			ptrs_pkg::OP_LIST: begin
				n = c.req;
				if (n > tbl_count) n = tbl_count;
				if (n > ptrs_pkg::MAX_RESULTS) n = ptrs_pkg::MAX_RESULTS;
				if (n == 0) begin
					push_word('0, ptrs_pkg::ST_EMPTY, '0, 1'b1);
					return;
				end
				// Partial shuffle: each chosen entry is swapped into place.
				for (k = 0; k < n; k++) begin
					pick = k + (gen_step() % (tbl_count - k));
					te = tbl_ep[pick];
					tl = tbl_seen[pick];
					push_word(te, ptrs_pkg::ST_LISTED, '0, k + 1 == n);
					tbl_ep[pick] = tbl_ep[k];
					tbl_seen[pick] = tbl_seen[k];
					tbl_ep[k] = te;
					tbl_seen[k] = tl;
				end
			end
			ptrs_pkg::OP_EXPIRE: begin
				removed = 0;
				k = 0;
				while (k < tbl_count) begin
					limit = {1'b0, tbl_seen[k]} + validity;
					if (limit < {1'b0, c.now}) begin
						tbl_ep[k] = tbl_ep[tbl_count - 1];
						tbl_seen[k] = tbl_seen[tbl_count - 1];
						tbl_count--;
						removed++;
					end else begin
						k++;
					end
				end
				push_word('0, ptrs_pkg::ST_EXPIRED, removed[ptrs_pkg::REQ_W-1:0], 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	// Command driver: bursts of words with random gaps in between.
	always @(posedge clk) begin
		peer_cmd_t c;
		if (start && !busy) predict_peers({operation, endpoint, request_count, now_seconds});
		if (start && busy) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (cmd_rd < cmd_wr && arst_n) begin
			c = cmd_buf[cmd_rd];
			cmd_rd++;
			operation <= c.op;
			endpoint <= c.ep;
			request_count <= c.req;
			now_seconds <= c.now;
			start <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 8);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Result monitor: every word is compared with the oldest prediction.
	always @(posedge clk) begin
		peer_word_t w;
		if (result_valid) begin
			if (exp_wr == exp_rd) begin
				$error("unexpected result word: status %0d", status);
				errors++;
			end else begin
				w = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (peer_endpoint !== w.ep) begin
					$error("peer_endpoint: expected %h, got %h", w.ep, peer_endpoint);
					errors++;
				end
				if (status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					errors++;
				end
				if (removed_count !== w.removed) begin
					$error("removed_count: expected %0d, got %0d", w.removed, removed_count);
					errors++;
				end
				if (last !== w.last) begin
					$error("last: expected %0d, got %0d", w.last, last);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [ptrs_pkg::CIDX_W-1:0] idx,
			logic [ptrs_pkg::RNG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == ptrs_pkg::REG_VALIDITY) begin
			validity = data[ptrs_pkg::VAL_W-1:0];
		end else if (idx == ptrs_pkg::REG_SEED) begin
			gen_state = (data == 0) ? 32'd1 : data;
		end
	endtask

	// Wait until every command has run and every word has come out.
	task automatic wait_idle();
		while (!(cmd_rd == cmd_wr && !start && !busy && exp_rd == exp_wr))
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_cmd(logic [ptrs_pkg::OP_W-1:0] op, logic [ptrs_pkg::EP_W-1:0] ep,
			logic [ptrs_pkg::REQ_W-1:0] req, logic [ptrs_pkg::TIME_W-1:0] now);
		cmd_buf[cmd_wr] = {op, ep, req, now};
		cmd_wr++;
	endtask

	// Random command mix: mostly adds from a reusable pool of endpoints.
	task automatic queue_random(int count);
		int r;
		logic [ptrs_pkg::EP_W-1:0] ep;
		logic [ptrs_pkg::TIME_W-1:0] now;
		repeat (count) begin
			r = $urandom_range(0, 99);
			clock_now += $urandom_range(0, 30);
			now = ($urandom_range(0, 32) == 0) ? $urandom : clock_now;
			if ($urandom_range(0, 6) == 0)
				ep = ptrs_pkg::EP_W'({$urandom, $urandom});
			else
				ep = ep_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (r < 55)
				queue_cmd(ptrs_pkg::OP_ADD, ep, ptrs_pkg::REQ_W'($urandom), now);
			else if (r < 80)
				queue_cmd(ptrs_pkg::OP_LIST, ep, ($urandom_range(0, 3) == 0)
					? ptrs_pkg::REQ_W'($urandom_range(0, 127))
					: ptrs_pkg::REQ_W'($urandom_range(1, 12)), now);
			else if (r < 95)
				queue_cmd(ptrs_pkg::OP_EXPIRE, ep, ptrs_pkg::REQ_W'($urandom), now);
			else
				queue_cmd(OP_UNUSED, ep, ptrs_pkg::REQ_W'($urandom), now);
		end
	endtask

	initial begin
		ep_pool[0] = '0;
		ep_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++) ep_pool[k] = ptrs_pkg::EP_W'({$urandom, $urandom});
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		queue_cmd(ptrs_pkg::OP_LIST, '1, 7'd5, 32'd0);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd0, 32'd0);
		queue_cmd(ptrs_pkg::OP_EXPIRE, '0, 7'd0, 32'd0);
		queue_cmd(ptrs_pkg::OP_ADD, '0, 7'd0, 32'd10);
		queue_cmd(ptrs_pkg::OP_ADD, '1, '1, 32'd20);
		queue_cmd(ptrs_pkg::OP_ADD, '0, 7'd0, 32'd30);
		queue_cmd(ptrs_pkg::OP_ADD, 48'h0a00_0001_1f90, 7'd0, 32'd25);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd0, 32'd40);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd127, 32'd40);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd1, 32'd40);
		queue_cmd(OP_UNUSED, '1, '1, '1);
		queue_cmd(ptrs_pkg::OP_EXPIRE, '0, 7'd0, 32'd3630);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd64, 32'd3630);
		queue_cmd(ptrs_pkg::OP_EXPIRE, '0, 7'd0, '1);
		queue_cmd(ptrs_pkg::OP_ADD, 48'h5555_aaaa_5555, 7'd0, '1);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd64, '1);
		queue_cmd(ptrs_pkg::OP_EXPIRE, '0, 7'd0, '1);
		wait_idle();

		// Shortest validity and a zero seed, plus a write to no register.
		write_reg(ptrs_pkg::REG_VALIDITY, 32'd1);
		write_reg(ptrs_pkg::REG_SEED, 32'd0);
		write_reg(REG_NONE, '1);
		queue_random(50);
		wait_idle();

		// Longest validity lets the table fill and drop adds.
		write_reg(ptrs_pkg::REG_VALIDITY, 32'hffff);
		write_reg(ptrs_pkg::REG_SEED, 32'hffff_ffff);
		queue_random(60);
		for (int k = 0; k < 70; k++) queue_cmd(ptrs_pkg::OP_ADD, ep_pool[k], '0, clock_now);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd64, clock_now);
		queue_cmd(ptrs_pkg::OP_LIST, '0, 7'd127, clock_now);
		wait_idle();

		write_reg(ptrs_pkg::REG_VALIDITY, $urandom_range(1, 200));
		write_reg(ptrs_pkg::REG_SEED, $urandom);
		queue_random(50);
		wait_idle();

		write_reg(ptrs_pkg::REG_VALIDITY, 32'(ptrs_pkg::VALIDITY_RST));
		write_reg(ptrs_pkg::REG_SEED, $urandom);
		queue_random(50);
		wait_idle();

		if (errors == 0 && exp_wr == exp_rd) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Run limit well beyond the slowest correct run.
	initial begin
		#60000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
sv/ptrs_pkg.sv
sv/ptrs_slot_mem.sv
sv/peer_table_random_sampler_top.sv
dv/testbench.sv
